// ===== hdl/dllm_pkg.sv =====
`default_nettype none
package dllm_pkg;

    // Node index width follows the input field; the pool covers every index
    localparam int IDX_W      = 8;
    localparam int NODE_COUNT = 2 ** IDX_W;
    // A link carries one extra top bit that marks "no node"
    localparam int LINK_W     = IDX_W + 1;
    localparam int ACT_W      = 3;
    localparam int ST_W       = 2;

    localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {IDX_W{1'b0}}};

    // Request actions
    localparam logic [ACT_W-1:0] ACT_ADD_TAIL  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_HEAD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TAKE_TAIL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TAKE_HEAD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ERASE     = 3'd4;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_MEMBER = 2'd2;
    localparam logic [ST_W-1:0] ST_IS_MEMBER  = 2'd3;

    // One port pair of a link memory, as driven by the controller
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LINK_W-1:0] wr_data;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== hdl/dllm_ram.sv =====
`default_nettype none
module dllm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/dllm_ctrl.sv =====
`default_nettype none
module dllm_ctrl
    import dllm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [IDX_W-1:0]  i_node_index,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [IDX_W-1:0]  o_result_node,
    output logic      [ST_W-1:0]   o_status,
    output t_mem_req               o_next_req,
    output t_mem_req               o_prev_req,
    input  wire logic [LINK_W-1:0] i_next_data,
    input  wire logic [LINK_W-1:0] i_prev_data
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state, n_state;
    logic [LINK_W-1:0]   r_head, n_head;
    logic [LINK_W-1:0]   r_tail, n_tail;
    logic [NODE_COUNT-1:0] r_member, n_member;
    logic                r_out_valid, n_out_valid;
    logic [ACT_W-1:0]    r_action;
    logic [IDX_W-1:0]    r_node;
    logic [LINK_W-1:0]   r_pick, n_pick;
    logic [IDX_W-1:0]    r_res;
    logic [ST_W-1:0]     r_st;

    logic                in_acc;
    logic                exec_go;
    logic                do_unlink;
    logic [IDX_W-1:0]    res;
    logic [ST_W-1:0]     st;
    logic [IDX_W-1:0]    x_idx;
    logic [LINK_W-1:0]   nx;
    logic [LINK_W-1:0]   pv;
    logic                next_wr, prev_wr;
    logic [IDX_W-1:0]    next_wr_addr, prev_wr_addr;
    logic [LINK_W-1:0]   next_wr_data, prev_wr_data;

    // Take a request only between items; finish once the output register has room
    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign exec_go = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // Choose the node whose links are read: tail or head for pops, else the given node
    always_comb begin
        case (i_action)
            ACT_TAKE_TAIL: n_pick = r_tail;
            ACT_TAKE_HEAD: n_pick = r_head;
            default:       n_pick = {1'b0, i_node_index};
        endcase
    end

    // Work out the list update from the links read back
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_member     = r_member;
        res          = r_node;
        st           = ST_OK;
        do_unlink    = 1'b0;
        next_wr      = 1'b0;
        prev_wr      = 1'b0;
        next_wr_addr = r_node;
        prev_wr_addr = r_node;
        next_wr_data = LINK_NONE;
        prev_wr_data = LINK_NONE;
        x_idx        = r_pick[IDX_W-1:0];
        // The tail has no successor and the head no predecessor
        nx = ({1'b0, x_idx} == r_tail) ? LINK_NONE : i_next_data;
        pv = ({1'b0, x_idx} == r_head) ? LINK_NONE : i_prev_data;

        case (r_action)
            ACT_ADD_TAIL, ACT_ADD_HEAD: begin
                if (r_member[r_node]) begin
                    st = ST_IS_MEMBER;
                end else begin
                    n_member[r_node] = 1'b1;
                    if (r_head[IDX_W]) begin
                        n_head = {1'b0, r_node};
                        n_tail = {1'b0, r_node};
                    end else if (r_action == ACT_ADD_TAIL) begin
                        next_wr      = 1'b1;
                        next_wr_addr = r_tail[IDX_W-1:0];
                        next_wr_data = {1'b0, r_node};
                        prev_wr      = 1'b1;
                        prev_wr_addr = r_node;
                        prev_wr_data = r_tail;
                        n_tail       = {1'b0, r_node};
                    end else begin
                        prev_wr      = 1'b1;
                        prev_wr_addr = r_head[IDX_W-1:0];
                        prev_wr_data = {1'b0, r_node};
                        next_wr      = 1'b1;
                        next_wr_addr = r_node;
                        next_wr_data = r_head;
                        n_head       = {1'b0, r_node};
                    end
                end
            end
            ACT_TAKE_TAIL, ACT_TAKE_HEAD: begin
                if (r_pick[IDX_W]) begin
                    res = '0;
                    st  = ST_EMPTY;
                end else begin
                    res       = x_idx;
                    do_unlink = 1'b1;
                end
            end
            ACT_ERASE: begin
                if (r_member[r_node]) begin
                    do_unlink = 1'b1;
                end else begin
                    st = ST_NOT_MEMBER;
                end
            end
            default: begin
            end
        endcase

        // Splice the node out: relink its neighbours or move head and tail
        if (do_unlink) begin
            n_member[x_idx] = 1'b0;
            if (nx[IDX_W]) begin
                n_tail = pv;
            end else begin
                prev_wr      = 1'b1;
                prev_wr_addr = nx[IDX_W-1:0];
                prev_wr_data = pv;
            end
            if (pv[IDX_W]) begin
                n_head = nx;
            end else begin
                next_wr      = 1'b1;
                next_wr_addr = pv[IDX_W-1:0];
                next_wr_data = nx;
            end
        end
    end

    // Issue the link reads at acceptance; write back only when the item completes
    always_comb begin
        o_next_req.rd_en   = in_acc;
        o_next_req.rd_addr = n_pick[IDX_W-1:0];
        o_prev_req.rd_en   = in_acc;
        o_prev_req.rd_addr = n_pick[IDX_W-1:0];
        o_next_req.wr_en   = exec_go && next_wr;
        o_next_req.wr_addr = next_wr_addr;
        o_next_req.wr_data = next_wr_data;
        o_prev_req.wr_en   = exec_go && prev_wr;
        o_prev_req.wr_addr = prev_wr_addr;
        o_prev_req.wr_data = prev_wr_data;
    end

    // Sequence and output occupancy
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_EXEC;
            S_EXEC:  if (exec_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_out_valid = exec_go || (r_out_valid && i_out_stall);
    end

    // Hold state, list ends, membership and the output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= LINK_NONE;
            r_tail      <= LINK_NONE;
            r_member    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (exec_go) begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_member <= n_member;
            end
        end
    end

    // Latch the request and the result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_node   <= i_node_index;
            r_pick   <= n_pick;
        end
        if (exec_go) begin
            r_res <= res;
            r_st  <= st;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_node = r_res;
    assign o_status      = r_st;

endmodule
`default_nettype wire

// ===== hdl/doubly_linked_list_manager_top.sv =====
`default_nettype none
// Doubly linked list manager over a pool of 256 nodes.
// Input channel: i_in_valid with o_in_stall carries one request, an action
// (push back, push front, pop back, pop front, erase) and a node index.
// Output channel: o_out_valid with i_out_stall carries one result per
// request: the popped node (or the echoed node index) and a status code.
// A request is taken at an edge where valid is high and stall is low.
// The link memories are read when the request is taken; the result is then
// registered once the output register is free, and o_out_valid rises with it.
// A new request waits until the last one has finished the read-modify-write
// of the next and previous link memories (read at acceptance, written at the end).
// While a request is in progress o_in_stall is high.
// A stalled receiver holds the finished result in the output register; the
// next request may still be taken, and it waits for the register to drain
// before its links are written back.
// Reset clears the head, tail and all membership bits; the link memories
// need no clearing, as only links of member nodes are read.
module doubly_linked_list_manager_top
    import dllm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire logic [IDX_W-1:0] i_node_index,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic      [IDX_W-1:0] o_result_node,
    output logic      [ST_W-1:0]  o_status
);

    t_mem_req          next_req;
    t_mem_req          prev_req;
    logic [LINK_W-1:0] next_data;
    logic [LINK_W-1:0] prev_data;

    // Control and list ends
    dllm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_node_index  (i_node_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_node (o_result_node),
        .o_status      (o_status),
        .o_next_req    (next_req),
        .o_prev_req    (prev_req),
        .i_next_data   (next_data),
        .i_prev_data   (prev_data)
    );

    // Successor links
    dllm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NODE_COUNT)
    ) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_req.wr_en),
        .i_wr_addr (next_req.wr_addr),
        .i_wr_data (next_req.wr_data),
        .i_rd_en   (next_req.rd_en),
        .i_rd_addr (next_req.rd_addr),
        .o_rd_data (next_data)
    );

    // Predecessor links
    dllm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NODE_COUNT)
    ) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_req.wr_en),
        .i_wr_addr (prev_req.wr_addr),
        .i_wr_data (prev_req.wr_data),
        .i_rd_en   (prev_req.rd_en),
        .i_rd_addr (prev_req.rd_addr),
        .o_rd_data (prev_data)
    );

endmodule
`default_nettype wire

// ===== verif/tb_doubly_linked_list_manager_top.sv =====
module tb_doubly_linked_list_manager_top;
    import dllm_pkg::*;

    localparam int unsigned RANDOM_REQUESTS = 850;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned HOLD_CYCLES     = 150;
    localparam int unsigned HOLD_SPACING    = 400;
    localparam int unsigned TAIL_CYCLES     = 10;
    localparam int unsigned PRINT_CAP       = 40;

    // Actions the block does not define; they only echo the node
    localparam logic [ACT_W-1:0] ACT_RSVD_LO = ACT_ERASE + 1'b1;
    localparam logic [ACT_W-1:0] ACT_RSVD_HI = '1;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] node;
        bit               drain_first;
    } t_request;

    typedef struct {
        logic [IDX_W-1:0] node;
        logic [ST_W-1:0]  status;
    } t_result;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic [ACT_W-1:0] i_action     = '0;
    logic [IDX_W-1:0] i_node_index = '0;
    logic             i_out_stall  = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [IDX_W-1:0] o_result_node;
    logic [ST_W-1:0]  o_status;

    doubly_linked_list_manager_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_node_index  (i_node_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_node (o_result_node),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Request plan and its own view of list membership
    t_request    pending_requests[$];
    int unsigned plan_order[$];
    bit          plan_member[NODE_COUNT];
    int unsigned planned_total = 0;
    int unsigned random_count  = 0;

    // Expected list state, kept as head/tail plus per-node links
    t_result           expected_results[$];
    logic [LINK_W-1:0] list_head = LINK_NONE;
    logic [LINK_W-1:0] list_tail = LINK_NONE;
    logic [LINK_W-1:0] next_link[NODE_COUNT];
    logic [LINK_W-1:0] prev_link[NODE_COUNT];
    bit                in_list[NODE_COUNT];
    int unsigned       list_depth = 0;
    int unsigned       depth_peak = 0;
    int unsigned       status_count[4];

    int unsigned accepted_count = 0;
    int unsigned results_seen   = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 3);
        else if (roll < 94)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Queue a request and track which nodes it leaves in the list
    task automatic plan_request(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] node,
                                input bit drain_first);
        t_request req;
        int       pos;
        pos = 0;
        req.action      = act;
        req.node        = node;
        req.drain_first = drain_first;
        pending_requests.insert(pending_requests.size(), req);
        planned_total++;
        case (act)
            ACT_ADD_TAIL, ACT_ADD_HEAD: begin
                if (!plan_member[node]) begin
                    plan_member[node] = 1'b1;
                    if (act == ACT_ADD_TAIL)
                        plan_order.insert(plan_order.size(), node);
                    else
                        plan_order.insert(0, node);
                end
            end
            ACT_TAKE_TAIL: begin
                if (plan_order.size() > 0) begin
                    plan_member[plan_order[plan_order.size() - 1]] = 1'b0;
                    plan_order.delete(plan_order.size() - 1);
                end
            end
            ACT_TAKE_HEAD: begin
                if (plan_order.size() > 0) begin
                    plan_member[plan_order[0]] = 1'b0;
                    plan_order.delete(0);
                end
            end
            ACT_ERASE: begin
                if (plan_member[node]) begin
                    plan_member[node] = 1'b0;
                    foreach (plan_order[i])
                        if (plan_order[i] == node)
                            pos = i;
                    plan_order.delete(pos);
                end
            end
            default: ;
        endcase
    endtask

    // Pick one random request; push_weight sets how fast the list grows
    task automatic plan_random(input int unsigned push_weight);
        int unsigned      roll;
        int unsigned      tries;
        logic [IDX_W-1:0] node;
        logic [ACT_W-1:0] act;
        bit               drain_first;
        roll = $urandom_range(0, 99);
        node = IDX_W'($urandom_range(0, NODE_COUNT - 1));
        act  = $urandom_range(0, 1) ? ACT_ADD_TAIL : ACT_ADD_HEAD;
        if (roll < push_weight) begin
            // aim for a free node, scanning once random tries run out
            tries = 0;
            while (plan_member[node] && tries < 16) begin
                node = IDX_W'($urandom_range(0, NODE_COUNT - 1));
                tries++;
            end
            if (plan_member[node])
                foreach (plan_member[i])
                    if (!plan_member[i])
                        node = IDX_W'(i);
        end else if (roll < push_weight + 4) begin
            if (plan_order.size() > 0)
                node = IDX_W'(plan_order[$urandom_range(0, plan_order.size() - 1)]);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                act = $urandom_range(0, 1) ? ACT_TAKE_TAIL : ACT_TAKE_HEAD;
            end else if (roll < 80) begin
                act = ACT_ERASE;
                if (plan_order.size() > 0)
                    node = IDX_W'(plan_order[$urandom_range(0, plan_order.size() - 1)]);
            end else if (roll < 92) begin
                act = ACT_ERASE;
            end else begin
                act = ACT_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
            end
        end
        drain_first = (random_count == 400) || (random_count == 700);
        random_count++;
        plan_request(act, node, drain_first);
    endtask

    // Unlink a member node and patch its neighbours
    task automatic detach_node(input logic [IDX_W-1:0] n);
        logic [LINK_W-1:0] succ;
        logic [LINK_W-1:0] pred;
        succ = next_link[n];
        pred = prev_link[n];
        if (succ[LINK_W-1])
            list_tail = pred;
        else
            prev_link[succ[IDX_W-1:0]] = pred;
        if (pred[LINK_W-1])
            list_head = succ;
        else
            next_link[pred[IDX_W-1:0]] = succ;
        in_list[n] = 1'b0;
        list_depth--;
    endtask

    // Work out the result of one accepted request and advance the list
    task automatic predict_request(input logic [ACT_W-1:0] act,
                                   input logic [IDX_W-1:0] node);
        t_result           res;
        logic [LINK_W-1:0] pick;
        res.node   = node;
        res.status = ST_OK;
        case (act)
            ACT_ADD_TAIL, ACT_ADD_HEAD: begin
                if (in_list[node]) begin
                    res.status = ST_IS_MEMBER;
                end else begin
                    if (list_head[LINK_W-1]) begin
                        list_head       = {1'b0, node};
                        list_tail       = {1'b0, node};
                        next_link[node] = LINK_NONE;
                        prev_link[node] = LINK_NONE;
                    end else if (act == ACT_ADD_TAIL) begin
                        next_link[list_tail[IDX_W-1:0]] = {1'b0, node};
                        prev_link[node] = list_tail;
                        next_link[node] = LINK_NONE;
                        list_tail       = {1'b0, node};
                    end else begin
                        prev_link[list_head[IDX_W-1:0]] = {1'b0, node};
                        next_link[node] = list_head;
                        prev_link[node] = LINK_NONE;
                        list_head       = {1'b0, node};
                    end
                    in_list[node] = 1'b1;
                    list_depth++;
                    if (list_depth > depth_peak)
                        depth_peak = list_depth;
                end
            end
            ACT_TAKE_TAIL, ACT_TAKE_HEAD: begin
                pick = (act == ACT_TAKE_TAIL) ? list_tail : list_head;
                if (pick[LINK_W-1]) begin
                    res.node   = '0;
                    res.status = ST_EMPTY;
                end else begin
                    res.node = pick[IDX_W-1:0];
                    detach_node(pick[IDX_W-1:0]);
                end
            end
            ACT_ERASE: begin
                if (in_list[node])
                    detach_node(node);
                else
                    res.status = ST_NOT_MEMBER;
            end
            default: ;
        endcase
        status_count[res.status]++;
        expected_results.insert(expected_results.size(), res);
    endtask

    // Send requests from the plan, with random gaps between them
    int unsigned send_gap    = 0;
    int unsigned send_steady = 0;

    always @(posedge i_clk) begin : drive_requests
        logic     next_valid;
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            // record the request taken at this edge
            if (i_in_valid && !o_in_stall) begin
                predict_request(i_action, i_node_index);
                accepted_count++;
                next_valid = 1'b0;
            end
            // offer the next one once the channel is free
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].drain_first &&
                               expected_results.size() > 0)) begin
                    req = pending_requests[0];
                    pending_requests.delete(0);
                    i_action     <= req.action;
                    i_node_index <= req.node;
                    next_valid   = 1'b1;
                    if (send_steady > 0) begin
                        send_steady--;
                        send_gap = 0;
                    end else if ($urandom_range(0, 99) < 3) begin
                        send_steady = $urandom_range(20, 60);
                        send_gap    = 0;
                    end else if ($urandom_range(0, 1)) begin
                        send_gap = 0;
                    end else begin
                        send_gap = idle_length();
                    end
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Stall the result channel: random stalls, free runs and long hold-offs
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 250;
    int unsigned stall_left   = 0;
    int unsigned ready_left   = 0;

    always @(posedge i_clk) begin : pace_results
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (results_seen >= next_hold_at) begin
            hold_left    = HOLD_CYCLES - 1;
            next_hold_at = next_hold_at + HOLD_SPACING;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 1)) begin
            ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 4);
            i_out_stall <= 1'b0;
        end else begin
            stall_left = idle_length() - 1;
            i_out_stall <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result node %0d status %0d",
                                          o_result_node, o_status));
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (o_result_node !== want.node)
                    report_mismatch($sformatf("result node %0d, expected %0d",
                                              o_result_node, want.node));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("tb_doubly_linked_list_manager_top failed");
        $finish;
    end

    initial begin : run_sequence
        int unsigned segment;
        int unsigned seg_len;
        int unsigned weight;
        segment = 0;

        // Directed: ends of the index range, middle and end erases,
        // rejected pushes and erases, pops on an empty list, unused actions
        plan_request(ACT_ADD_TAIL,   8'd0,   1'b0);
        plan_request(ACT_ADD_TAIL,   8'd255, 1'b0);
        plan_request(ACT_ADD_HEAD,   8'd128, 1'b0);
        plan_request(ACT_ADD_HEAD,   8'd0,   1'b0);
        plan_request(ACT_ERASE,      8'd0,   1'b0);
        plan_request(ACT_ERASE,      8'd0,   1'b0);
        plan_request(ACT_TAKE_TAIL,  8'd0,   1'b0);
        plan_request(ACT_TAKE_HEAD,  8'd0,   1'b0);
        plan_request(ACT_TAKE_TAIL,  8'd17,  1'b0);
        plan_request(ACT_TAKE_HEAD,  8'd255, 1'b0);
        plan_request(ACT_ERASE,      8'd7,   1'b0);
        plan_request(ACT_ADD_HEAD,   8'd1,   1'b0);
        plan_request(ACT_ERASE,      8'd1,   1'b0);
        plan_request(ACT_ADD_TAIL,   8'd2,   1'b0);
        plan_request(ACT_ADD_TAIL,   8'd3,   1'b0);
        plan_request(ACT_ADD_TAIL,   8'd4,   1'b0);
        plan_request(ACT_ERASE,      8'd2,   1'b0);
        plan_request(ACT_ERASE,      8'd4,   1'b0);
        plan_request(ACT_TAKE_HEAD,  8'd0,   1'b0);
        plan_request(ACT_RSVD_LO,    8'hAA,  1'b0);
        plan_request(ACT_RSVD_LO + 1'b1, 8'h55, 1'b0);
        plan_request(ACT_RSVD_HI,    8'hFF,  1'b0);

        // Random segments that grow, shrink or churn the list; one fills it
        while (random_count < RANDOM_REQUESTS) begin
            if (segment == 2) begin
                while (plan_order.size() < NODE_COUNT)
                    plan_random(90);
                repeat (6) plan_random(90);
            end else begin
                case ($urandom_range(0, 2))
                    0:       weight = 15;
                    1:       weight = 45;
                    default: weight = 75;
                endcase
                seg_len = $urandom_range(60, 140);
                if (seg_len > RANDOM_REQUESTS - random_count)
                    seg_len = RANDOM_REQUESTS - random_count;
                repeat (seg_len) plan_random(weight);
            end
            segment++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < planned_total || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests checked: %0d ok, %0d empty pops, %0d absent erases",
                 accepted_count, status_count[ST_OK], status_count[ST_EMPTY],
                 status_count[ST_NOT_MEMBER]);
        $display("%0d repeat pushes; list depth reached %0d of %0d nodes; %0d mismatches",
                 status_count[ST_IS_MEMBER], depth_peak, NODE_COUNT, error_count);
        if (error_count == 0)
            $display("tb_doubly_linked_list_manager_top passed");
        else
            $display("tb_doubly_linked_list_manager_top failed");
        $finish;
    end

endmodule
